@@ src/dde_pkg.sv @@
// ----------------------------------------------------------------------------
// dde_pkg
// Shared constants and controller/datapath interface types for the decimal
// digit entry table.
// ----------------------------------------------------------------------------
`default_nettype none

package dde_pkg;

  // Storage sizes
  localparam int RING_DEPTH  = 16;   // 2 .. 31
  localparam int TABLE_DEPTH = 16;   // 1 .. 16

  // Derived widths
  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int SLOT_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HALF    = RING_DEPTH / 2;

  // Fixed field widths
  localparam int KEY_W    = 8;
  localparam int DIGIT_W  = 4;
  localparam int DCOUNT_W = 5;
  localparam int WORD_W   = 32;
  localparam int VALUE_W  = 2 * WORD_W;
  localparam int SLOT_OW  = 4;

  localparam int MAX_DIGIT = 9;

  // Input command codes
  localparam logic CMD_KEY    = 1'b0;
  localparam logic CMD_COMMIT = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic key_wr;      // accept a key item
    logic walk_start;  // accept a commit item, clear accumulators
    logic walk_step;   // fold one stored digit
    logic finish;      // publish commit result, clear ring
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic walk_done;   // every held digit has been folded
    logic out_free;    // output register can take a result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

@@ src/decimal_digit_entry_table.sv @@
// ----------------------------------------------------------------------------
// decimal_digit_entry_table
// Collects decimal key digits and packs them into 64-bit table entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries cmd_i and key_value_i.
//   cmd_i = 0 stores key_value_i when it is a digit 0..9; cmd_i = 1 commits
//   the held digits. Every input item yields exactly one result item on the
//   output channel (out_valid_o / out_stall_i).
//   Key item: result is registered and visible the cycle after acceptance.
//   Commit item: the held digits are folded one per cycle through a single
//   multiply-by-ten adder; the result is then loaded into the output
//   register once it is free. A commit blocks input for its walk.
//   Throughput: one key item per cycle while the output register is free.
//   A finished result sits in the output register; the next item is taken
//   while it is being handed over, but not while it is stalled.
//   Reset clears the ring fill count, write pointer, table slot and output
//   valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_digit_entry_table (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             cmd_i,
  input  wire logic [dde_pkg::KEY_W-1:0]        key_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [dde_pkg::DCOUNT_W-1:0]          digit_count_o,
  output logic                                  committed_o,
  output logic [dde_pkg::VALUE_W-1:0]           commit_value_o,
  output logic [dde_pkg::SLOT_OW-1:0]           commit_slot_o
);

  dde_pkg::ctrl_cmd_t  ctrl;
  dde_pkg::dp_status_t status;

  dde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  dde_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_value_i    (key_value_i),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digit_count_o  (digit_count_o),
    .committed_o    (committed_o),
    .commit_value_o (commit_value_o),
    .commit_slot_o  (commit_slot_o)
  );

endmodule

`default_nettype wire

@@ src/dde_ctrl.sv @@
// ----------------------------------------------------------------------------
// dde_ctrl
// Sequencer: accepts items, steps the digit walk on a commit and hands the
// result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dde_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               cmd_i,
  input  wire dde_pkg::dp_status_t status_i,
  output dde_pkg::ctrl_cmd_t      ctrl_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_stall_o = !((state_q == ST_IDLE) && status_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == dde_pkg::CMD_COMMIT) begin
            ctrl_o.walk_start = 1'b1;
            state_d           = ST_WALK;
          end else begin
            ctrl_o.key_wr = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (!status_i.walk_done) begin
          ctrl_o.walk_step = 1'b1;
        end else if (status_i.out_free) begin
          ctrl_o.finish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ src/dde_dp.sv @@
// ----------------------------------------------------------------------------
// dde_dp
// Datapath: digit ring, write pointer and fill count, decimal accumulators,
// table slot counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dde_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [dde_pkg::KEY_W-1:0]         key_value_i,
  input  wire dde_pkg::ctrl_cmd_t                ctrl_i,
  output dde_pkg::dp_status_t                    status_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [dde_pkg::DCOUNT_W-1:0]           digit_count_o,
  output logic                                   committed_o,
  output logic [dde_pkg::VALUE_W-1:0]            commit_value_o,
  output logic [dde_pkg::SLOT_OW-1:0]            commit_slot_o
);

  logic [dde_pkg::DIGIT_W-1:0] ring_q [dde_pkg::RING_DEPTH];

  logic [dde_pkg::RING_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [dde_pkg::CNT_W-1:0]   held_q, held_d;
  logic [dde_pkg::CNT_W-1:0]   idx_q, idx_d;
  logic [dde_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic [dde_pkg::WORD_W-1:0]  low_q, low_d, high_q, high_d;
  logic                        out_valid_q, out_valid_d;

  logic [dde_pkg::DCOUNT_W-1:0] cnt_out_q, cnt_out_d;
  logic                         comm_out_q, comm_out_d;
  logic [dde_pkg::VALUE_W-1:0]  val_out_q, val_out_d;
  logic [dde_pkg::SLOT_OW-1:0]  slot_out_q, slot_out_d;

  logic                        is_digit;
  logic                        load_out;
  logic [dde_pkg::DIGIT_W-1:0] rd_digit;
  logic [dde_pkg::WORD_W-1:0]  acc_in, acc_x10;

  assign is_digit = key_value_i <= dde_pkg::KEY_W'(dde_pkg::MAX_DIGIT);
  assign rd_digit = ring_q[idx_q[dde_pkg::RING_AW-1:0]];

  // Entries below the low/high boundary fold into the low word
  assign acc_in  = (idx_q < dde_pkg::CNT_W'(dde_pkg::HALF)) ? low_q : high_q;
  assign acc_x10 = (acc_in << 3) + (acc_in << 1)
                   + dde_pkg::WORD_W'(rd_digit);

  assign load_out          = ctrl_i.key_wr || ctrl_i.finish;
  assign status_o.walk_done = (idx_q == held_q);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    held_d      = held_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    low_d       = low_q;
    high_d      = high_q;
    cnt_out_d   = cnt_out_q;
    comm_out_d  = comm_out_q;
    val_out_d   = val_out_q;
    slot_out_d  = slot_out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (ctrl_i.key_wr) begin
      if (is_digit) begin
        wr_ptr_d = (wr_ptr_q == dde_pkg::RING_AW'(dde_pkg::RING_DEPTH - 1))
                   ? '0 : wr_ptr_q + 1'b1;
        if (held_q != dde_pkg::CNT_W'(dde_pkg::RING_DEPTH)) begin
          held_d = held_q + 1'b1;
        end
      end
      cnt_out_d  = dde_pkg::DCOUNT_W'(held_d);
      comm_out_d = 1'b0;
      val_out_d  = '0;
      slot_out_d = '0;
    end

    if (ctrl_i.walk_start) begin
      idx_d  = '0;
      low_d  = '0;
      high_d = '0;
    end

    if (ctrl_i.walk_step) begin
      if (idx_q < dde_pkg::CNT_W'(dde_pkg::HALF)) begin
        low_d = acc_x10;
      end else begin
        high_d = acc_x10;
      end
      idx_d = idx_q + 1'b1;
    end

    if (ctrl_i.finish) begin
      cnt_out_d  = '0;
      comm_out_d = 1'b1;
      val_out_d  = {high_q, low_q};
      slot_out_d = dde_pkg::SLOT_OW'(slot_q);
      slot_d     = (slot_q == dde_pkg::SLOT_W'(dde_pkg::TABLE_DEPTH - 1))
                   ? '0 : slot_q + 1'b1;
      wr_ptr_d   = '0;
      held_d     = '0;
    end

    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // Ring contents: only entries below the fill count are ever read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.key_wr && is_digit) begin
      ring_q[wr_ptr_q] <= key_value_i[dde_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      held_q      <= '0;
      idx_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      held_q      <= held_d;
      idx_q       <= idx_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q      <= low_d;
    high_q     <= high_d;
    cnt_out_q  <= cnt_out_d;
    comm_out_q <= comm_out_d;
    val_out_q  <= val_out_d;
    slot_out_q <= slot_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign digit_count_o  = cnt_out_q;
  assign committed_o    = comm_out_q;
  assign commit_value_o = val_out_q;
  assign commit_slot_o  = slot_out_q;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for decimal_digit_entry_table. Key and commit items are
// sent over the valid/stall input channel. A local model of the digit ring
// and table slot predicts one result per item, and each result taken from
// the output channel is compared field by field against the oldest
// prediction. Sender gaps and receiver stalls are varied phase by phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int CLK_PERIOD    = 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 80;
  localparam int KEY_RADIX     = 10;
  localparam int PHASE_ITEMS   = 250;

  typedef struct packed {
    logic [dde_pkg::DCOUNT_W-1:0] count;
    logic                         committed;
    logic [dde_pkg::VALUE_W-1:0]  value;
    logic [dde_pkg::SLOT_OW-1:0]  slot;
  } entry_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         cmd_i;
  logic [dde_pkg::KEY_W-1:0]    key_value_i;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [dde_pkg::DCOUNT_W-1:0] digit_count_o;
  logic                         committed_o;
  logic [dde_pkg::VALUE_W-1:0]  commit_value_o;
  logic [dde_pkg::SLOT_OW-1:0]  commit_slot_o;

  // Local copy of the block's state
  logic [dde_pkg::DIGIT_W-1:0] digit_ring_q [dde_pkg::RING_DEPTH];
  int unsigned                 ring_wr_ptr  = 0;
  int unsigned                 ring_held    = 0;
  int unsigned                 next_slot    = 0;

  entry_result_t expected_entries [$];

  int errors         = 0;
  int items_sent     = 0;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  decimal_digit_entry_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .key_value_i    (key_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digit_count_o  (digit_count_o),
    .committed_o    (committed_o),
    .commit_value_o (commit_value_o),
    .commit_slot_o  (commit_slot_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d results outstanding", $time,
               expected_entries.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or a forced hold-off while hold_left runs down
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic report_field(input string field,
                              input logic [dde_pkg::VALUE_W-1:0] want,
                              input logic [dde_pkg::VALUE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    entry_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_entries.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending, expected none, actual count %0d value %0h",
                 $time, digit_count_o, commit_value_o);
      end else begin
        want = expected_entries.pop_front();
        report_field("digit_count", want.count, digit_count_o);
        report_field("committed", want.committed, committed_o);
        report_field("commit_value", want.value, commit_value_o);
        report_field("commit_slot", want.slot, commit_slot_o);
      end
    end
  end

  // Folds the held digits on a commit; first half into the low word
  task automatic predict_entry(input logic cmd, input logic [dde_pkg::KEY_W-1:0] key);
    entry_result_t              r;
    logic [dde_pkg::WORD_W-1:0] lo;
    logic [dde_pkg::WORD_W-1:0] hi;
    r  = '0;
    lo = '0;
    hi = '0;
    if (cmd == dde_pkg::CMD_KEY) begin
      if (key <= dde_pkg::MAX_DIGIT) begin
        digit_ring_q[ring_wr_ptr] = key[dde_pkg::DIGIT_W-1:0];
        ring_wr_ptr = (ring_wr_ptr + 1) % dde_pkg::RING_DEPTH;
        if (ring_held < dde_pkg::RING_DEPTH) ring_held++;
      end
    end else begin
      for (int i = 0; i < ring_held; i++) begin
        if (i < dde_pkg::HALF) lo = lo * KEY_RADIX + digit_ring_q[i];
        else                   hi = hi * KEY_RADIX + digit_ring_q[i];
      end
      r.committed = 1'b1;
      r.value     = {hi, lo};
      r.slot      = dde_pkg::SLOT_OW'(next_slot);
      next_slot   = (next_slot + 1) % dde_pkg::TABLE_DEPTH;
      ring_held   = 0;
      ring_wr_ptr = 0;
    end
    r.count = dde_pkg::DCOUNT_W'(ring_held);
    expected_entries.push_back(r);
  endtask

  task automatic send_item(input logic cmd, input logic [dde_pkg::KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    key_value_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    predict_entry(cmd, key);
    items_sent++;
  endtask

  // Sender pauses until every outstanding result has been taken
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_entries.size() != 0);
  endtask

  // A number: some digits with occasional stray keys, then a commit
  task automatic send_random_number(input int min_digits, input int max_digits);
    int n;
    n = $urandom_range(max_digits, min_digits);
    repeat (n) begin
      if ($urandom_range(9) == 0)
        send_item(dde_pkg::CMD_KEY,
                  dde_pkg::KEY_W'($urandom_range(255, dde_pkg::MAX_DIGIT + 1)));
      send_item(dde_pkg::CMD_KEY, dde_pkg::KEY_W'($urandom_range(dde_pkg::MAX_DIGIT)));
    end
    send_item(dde_pkg::CMD_COMMIT, dde_pkg::KEY_W'($urandom_range(255)));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(4, 1))
      send_item(1'($urandom_range(1)), dde_pkg::KEY_W'($urandom_range(255)));
  endtask

  task automatic run_random(input int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(99) < 85)
        send_random_number(0, ($urandom_range(4) == 0) ? dde_pkg::RING_DEPTH + 8 : 12);
      else
        send_noise();
    end
  endtask

  task automatic test_directed();
    send_item(dde_pkg::CMD_COMMIT, 8'hFF);  // commit with nothing held
    send_item(dde_pkg::CMD_KEY, 8'd10);     // non-digit keys
    send_item(dde_pkg::CMD_KEY, 8'hFF);
    send_item(dde_pkg::CMD_KEY, 8'd0);
    repeat (7) send_item(dde_pkg::CMD_KEY, dde_pkg::KEY_W'(dde_pkg::MAX_DIGIT));
    send_item(dde_pkg::CMD_KEY, dde_pkg::KEY_W'(dde_pkg::MAX_DIGIT));  // spills into the upper word
    send_item(dde_pkg::CMD_KEY, 8'h80);
    send_item(dde_pkg::CMD_COMMIT, 8'h00);
    send_item(dde_pkg::CMD_KEY, 8'd7);
    send_item(dde_pkg::CMD_KEY, 8'd3);
    send_item(dde_pkg::CMD_COMMIT, 8'hAA);
    send_item(dde_pkg::CMD_KEY, 8'h55);
    send_item(dde_pkg::CMD_COMMIT, 8'h01);
    wait_all_results();
  endtask

  task automatic test_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    run_random(PHASE_ITEMS);
    wait_all_results();
  endtask

  // Fill the ring to capacity or beyond, so old digits may be overwritten before the commit
  task automatic test_full_ring();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    repeat (6) send_random_number(dde_pkg::RING_DEPTH, dde_pkg::RING_DEPTH + 8);
    wait_all_results();
  endtask

  // Long output hold-off while items keep coming, so the input backs up
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    run_random(40);
    wait_all_results();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = dde_pkg::CMD_KEY;
    key_value_i = '0;
    for (int i = 0; i < dde_pkg::RING_DEPTH; i++) digit_ring_q[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_phase(0, 0);
    test_phase(56, 0);
    test_phase(0, 56);
    test_phase(35, 35);
    test_full_ring();
    test_backpressure();

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/dde_pkg.sv
src/dde_ctrl.sv
src/dde_dp.sv
src/decimal_digit_entry_table.sv
tb/tb.sv
